// File: hdl/cms_pkg.sv
// ----------------------------------------------------------------------------
// cms_pkg: shared types and constants for the color matrix selector
// Holds the request and result payload structs, the table type and the
// configuration register indexes used by the search unit and the top level.
// ----------------------------------------------------------------------------
package cms_pkg;

  localparam int WINDOW        = 12;
  localparam int TABLE_ENTRIES = 6;
  localparam int REG_TEMPS     = 6;

  localparam int TEMP_W  = 16;
  localparam int IDX_W   = 3;
  localparam int AGREE_W = 4;
  localparam int CFG_W   = 3;

  // vote counts reach WINDOW, history addresses stay below it
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int HIST_W = $clog2(WINDOW);
  localparam int TE_W   = $clog2(TABLE_ENTRIES);

  // register indexes
  localparam logic [CFG_W-1:0] CFG_TEMP0 = 3'd0;
  localparam logic [CFG_W-1:0] CFG_TEMP5 = 3'd5;
  localparam logic [CFG_W-1:0] CFG_AGREE = 3'd6;

  localparam logic [TEMP_W-1:0]  TEMP0_RST = 16'd2800;
  localparam logic [TEMP_W-1:0]  TEMP1_RST = 16'd4000;
  localparam logic [TEMP_W-1:0]  TEMP2_RST = 16'd5000;
  localparam logic [TEMP_W-1:0]  TEMP3_RST = 16'd6500;
  localparam logic [AGREE_W-1:0] AGREE_RST = 4'd10;

  typedef logic [REG_TEMPS-1:0][TEMP_W-1:0] temp_tab_t;

  typedef struct packed {
    logic [TEMP_W-1:0] meas_temp;
    logic              restart;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] matrix_index;
    logic             apply;
  } out_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] index;
  } srch_res_t;

endpackage

// File: hdl/color_matrix_select_stabilizer.sv
// ----------------------------------------------------------------------------
// color_matrix_select_stabilizer: color matrix pick with vote stabilization
// Maps a measured color temperature to the nearest table entry and smooths
// the pick with a majority vote over the last twelve frames.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per frame, meas_temp plus restart flag.
//   out_* : one result per request, matrix_index plus apply flag.
//   cfg_* : register writes (table entries 0..5, agree count); always ready,
//           write only while no request is in flight.
// Timing:
//   A result is valid once its request has passed the table search (start,
//   one neighbor pair per cycle, handoff), the store of the pick, the vote
//   count that rotates the history past one counter update, the histogram
//   scan and the result register. in_ready is low during that time, so one
//   request is in work at a time; a new request is taken only once the
//   previous result has been registered.
// Reset:
//   Registers return to their default table and agree count, the vote window
//   empties, nothing counts as applied.
// Stall:
//   A result waits in the output register; the next request may be accepted
//   and runs until its result, which then holds until the register frees.
// ----------------------------------------------------------------------------
module color_matrix_select_stabilizer import cms_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_index,
  input  logic [TEMP_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEARCH, ST_WRITE, ST_COUNT, ST_BEST, ST_RESULT
  } state_t;

  // configuration
  temp_tab_t            temp_tab_r;
  logic [AGREE_W-1:0]   agree_r;

  // sequencer and vote state
  state_t               state_r;
  logic [TEMP_W-1:0]    temp_r;
  logic                 restart_r;
  logic                 srch_start_r;
  logic [IDX_W-1:0]     pick_r;
  logic [IDX_W-1:0]     hist_r [WINDOW];
  logic [CNT_W-1:0]     cnt_r [TABLE_ENTRIES];
  logic [CNT_W-1:0]     fill_r;
  logic [CNT_W-1:0]     len_r;
  logic [CNT_W-1:0]     ci_r;
  logic [TE_W-1:0]      bi_r;
  logic [IDX_W-1:0]     best_r;
  logic [CNT_W-1:0]     best_n_r;
  logic [IDX_W-1:0]     held_r;
  logic [IDX_W-1:0]     applied_r;
  logic                 applied_vld_r;
  logic                 out_valid_r;
  out_t                 out_r;

  srch_res_t            srch;
  logic [CNT_W-1:0]     fill_eff;
  logic [IDX_W-1:0]     vote;
  logic                 maj_ok;
  logic [IDX_W-1:0]     result;
  logic                 load_out;

  cms_search u_search (
    .clk   (clk),
    .rst_n (rst_n),
    .start (srch_start_r),
    .temp  (temp_r),
    .tab   (temp_tab_r),
    .res   (srch)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_tab_r <= {{(2*TEMP_W){1'b0}}, TEMP3_RST, TEMP2_RST, TEMP1_RST, TEMP0_RST};
      agree_r <= AGREE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index) inside
        [CFG_TEMP0:CFG_TEMP5]: temp_tab_r[cfg_index] <= cfg_data;
        CFG_AGREE:             agree_r <= cfg_data[AGREE_W-1:0];
        default:               ;
      endcase
    end
  end

  always_comb begin
    fill_eff = in_data.restart ? CNT_W'(1) : fill_r;
    vote     = hist_r[0];
    maj_ok   = (len_r < CNT_W'(WINDOW)) ||
               ({{AGREE_W{1'b0}}, best_n_r} >= {{CNT_W{1'b0}}, agree_r});
    result   = maj_ok ? best_r : held_r;
    load_out = (state_r == ST_RESULT) && (!out_valid_r || out_ready);
  end

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      srch_start_r  <= 1'b0;
      fill_r        <= CNT_W'(1);
      held_r        <= '0;
      applied_r     <= '0;
      applied_vld_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      srch_start_r <= (state_r == ST_IDLE) && in_valid;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            temp_r       <= in_data.meas_temp;
            restart_r    <= in_data.restart;
            len_r        <= fill_eff;
            fill_r       <= (fill_eff < CNT_W'(WINDOW)) ? fill_eff + 1'b1 : fill_eff;
            if (in_data.restart) begin
              held_r <= '0;
            end
            state_r      <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (srch.done) begin
            pick_r  <= srch.index;
            state_r <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          // full window: drop the oldest pick, append at the end
          if (len_r == CNT_W'(WINDOW)) begin
            for (int i = 0; i < WINDOW - 1; i++) begin
              hist_r[i] <= hist_r[i+1];
            end
            hist_r[WINDOW-1] <= pick_r;
          end else begin
            hist_r[HIST_W'(len_r - 1'b1)] <= pick_r;
          end
          for (int j = 0; j < TABLE_ENTRIES; j++) begin
            cnt_r[j] <= '0;
          end
          ci_r    <= '0;
          state_r <= ST_COUNT;
        end
        ST_COUNT: begin
          // rotate a full turn so the history ends in its original order
          for (int i = 0; i < WINDOW - 1; i++) begin
            hist_r[i] <= hist_r[i+1];
          end
          hist_r[WINDOW-1] <= hist_r[0];
          if ((ci_r < len_r) && (vote < IDX_W'(TABLE_ENTRIES))) begin
            cnt_r[vote[TE_W-1:0]] <= cnt_r[vote[TE_W-1:0]] + 1'b1;
          end
          ci_r <= ci_r + 1'b1;
          if (ci_r == CNT_W'(WINDOW - 1)) begin
            bi_r     <= '0;
            best_r   <= '0;
            best_n_r <= '0;
            state_r  <= ST_BEST;
          end
        end
        ST_BEST: begin
          // strict compare keeps the lowest index on a tie
          if (cnt_r[bi_r] > best_n_r) begin
            best_n_r <= cnt_r[bi_r];
            best_r   <= IDX_W'(bi_r);
          end
          bi_r <= bi_r + 1'b1;
          if (bi_r == TE_W'(TABLE_ENTRIES - 1)) begin
            state_r <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (load_out) begin
            held_r             <= result;
            applied_r          <= result;
            applied_vld_r      <= 1'b1;
            out_r.matrix_index <= result;
            out_r.apply        <= !applied_vld_r || (result != applied_r) || restart_r;
            state_r            <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: hdl/cms_search.sv
// ----------------------------------------------------------------------------
// cms_search: iterative nearest-entry table search
// Walks the temperature table one neighbor pair per cycle with two subtracts
// and a compare, rounds to the closer entry and clamps at the ends.
// ----------------------------------------------------------------------------
module cms_search import cms_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TEMP_W-1:0] temp,
  input  temp_tab_t         tab,
  output srch_res_t         res
);

  typedef enum logic {SR_IDLE, SR_STEP} sr_state_t;

  sr_state_t         state_r;
  logic [IDX_W-1:0]  k_r;
  srch_res_t         res_r;

  logic [IDX_W:0]    k1;
  logic [TEMP_W-1:0] e_next;
  logic              has_next;
  logic [TEMP_W:0]   below;
  logic [TEMP_W:0]   above;
  logic              brk;
  logic              closer;

  always_comb begin
    k1       = {1'b0, k_r} + 1'b1;
    e_next   = (k1 < (IDX_W+1)'(TABLE_ENTRIES)) ? tab[k1[IDX_W-1:0]] : '0;
    has_next = (k1 < (IDX_W+1)'(TABLE_ENTRIES)) && (e_next != '0);
    below    = {1'b0, temp} - {1'b0, tab[k_r]};
    above    = {1'b0, e_next} - {1'b0, temp};
    // stop once the temperature lies at or below the upper neighbor, or below the current entry
    brk      = below[TEMP_W] | ~above[TEMP_W];
    closer   = $signed(above) < $signed(below);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= SR_IDLE;
      res_r.done <= 1'b0;
    end else begin
      res_r.done <= (state_r == SR_STEP) && (!has_next || brk);
      unique case (state_r)
        SR_IDLE: begin
          if (start) begin
            k_r     <= '0;
            state_r <= SR_STEP;
          end
        end
        SR_STEP: begin
          if (!has_next) begin
            res_r.index <= k_r;
            state_r     <= SR_IDLE;
          end else if (brk) begin
            res_r.index <= k_r + IDX_W'(closer);
            state_r     <= SR_IDLE;
          end else begin
            k_r <= k1[IDX_W-1:0];
          end
        end
        default: state_r <= SR_IDLE;
      endcase
    end
  end

  assign res = res_r;

endmodule

// File: hdl/cms_checker.sv
// ----------------------------------------------------------------------------
// cms_checker: port-level checks for the color matrix selector
// Watches the request and result ports over time.
// ----------------------------------------------------------------------------
module cms_checker import cms_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input in_t               in_data,
  input logic              out_valid,
  input logic              out_ready,
  input out_t              out_data
);

  // a waiting request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("request changed or dropped while waiting");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // one request in work at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // reset leaves no result pending
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // stabilized index stays inside the table
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.matrix_index < IDX_W'(TABLE_ENTRIES))
    else $error("matrix index out of range");

endmodule

bind color_matrix_select_stabilizer cms_checker u_cms_checker (.*);
